// ===== hdl/scmv_pkg.sv =====
`default_nettype none
package scmv_pkg;
  localparam int Faces = 1024;
  localparam int Colors = 32;
  localparam int CountBits = 24;
  localparam int FaceBits = 10;
  localparam int ColorBits = 5;
  localparam int AddrBits = FaceBits + ColorBits;
  localparam int Depth = Faces * Colors;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0, OP_PIXEL = 2'd1, OP_QUERY = 2'd2, OP_CLEAR = 2'd3
  } opcode_t;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_BACKGROUND = 3'd1;
  localparam logic [2:0] ST_UNMATCHED = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_QUERY = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int RegRadix = 0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] id_red;
    logic [7:0] id_green;
    logic [7:0] id_blue;
    logic [4:0] entry_index;
    logic       entry_excluded;
    logic [9:0] face_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  face_index;
    logic [4:0]  matched_color;
    logic        winner_found;
    logic [4:0]  winner_color;
    logic [23:0] winner_count;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/scmv_stream_if.sv =====
`default_nettype none
interface scmv_in_if import scmv_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface scmv_out_if import scmv_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/segment_color_majority_vote_core.sv =====
// steps: a load goes straight to the output; a pixel forms its id and, if counted,
// reads then writes its counter; a query scans every color, then loads the winner;
// clear zeroes one counter per cycle. One item at a time: input is taken only in
// idle; the count memory has one write port and one registered read port
// reset: palette all invalid, radix 256, then a clearing pass over all
// Faces*Colors counters zeroes the count memory before the first item
`default_nettype none
module segment_color_majority_vote_core import scmv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  scmv_in_if.sink          in_ch,
  scmv_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ID, S_RMW_RD, S_RMW_WR, S_SCAN, S_WIN, S_OUT
  } state_t;

  state_t           state;
  logic [8:0]       radix;
  in_item_t         item;
  logic [AddrBits-1:0] sweep;
  logic             clr_reply;
  logic [ColorBits:0]  scan;
  logic             scan_live;
  logic [ColorBits-1:0] scan_col;
  logic [17:0]      rr;
  logic [17:0]      gx;
  logic [27:0]      id_hi;
  logic signed [29:0] id;
  logic             hit;
  logic [ColorBits-1:0] hit_index;
  logic             eligible;
  logic [FaceBits-1:0] face;
  logic [ColorBits-1:0] col;
  logic             best_found;
  logic [ColorBits-1:0] best;
  logic [CountBits-1:0] best_cnt;
  out_item_t        result;

  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  logic [CountBits-1:0] ram_wdata;
  logic [AddrBits-1:0]  ram_raddr;
  logic [CountBits-1:0] ram_rdata;

  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = result;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(RegRadix * 4)) ? {23'd0, radix} : 32'd0;

  scmv_palette u_palette (
    .clk, .rst,
    .we        (in_xfer && opcode_t'(in_ch.payload.opcode) == OP_LOAD),
    .windex    (in_ch.payload.entry_index),
    .wexcl     (in_ch.payload.entry_excluded),
    .wrgb      ({in_ch.payload.pixel_red, in_ch.payload.pixel_green,
                 in_ch.payload.pixel_blue}),
    .match_rgb ({item.pixel_red, item.pixel_green, item.pixel_blue}),
    .hit, .hit_index,
    .elig_index (scan_col),
    .eligible
  );

  scmv_ram #(.Width(CountBits), .Depth(Depth)) u_counts (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // memory port steering
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = {face, col};
    ram_wdata = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + 1'b1;
    ram_raddr = {face, col};
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = sweep;
      ram_wdata = '0;
    end else if (state == S_RMW_WR) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN) begin
      ram_raddr = {item.face_select, scan[ColorBits-1:0]};
    end
  end

  // id = (r*x + g)*x + b - 1, one multiply per cycle
  assign gx = rr + 18'(item.id_green);
  assign id_hi = gx * 28'(radix);
  assign id = 30'(id_hi) + 30'(item.id_blue) - 30'sd1;

  assign scan_col = scan[ColorBits-1:0] - 1'b1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      clr_reply <= 1'b0;
      radix <= 9'd256;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'(RegRadix * 4)) begin
        radix <= pwdata[8:0];
      end
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == AddrBits'(Depth - 1)) begin
            clr_reply <= 1'b0;
            state <= clr_reply ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            item <= in_ch.payload;
            rr <= 18'(in_ch.payload.id_red) * 18'(radix);
            result <= '{status: ST_DONE, default: '0};
            unique case (opcode_t'(in_ch.payload.opcode))
              OP_LOAD: state <= S_OUT;
              OP_PIXEL: state <= S_ID;
              OP_QUERY: begin
                scan <= '0;
                scan_live <= 1'b0;
                best_found <= 1'b0;
                best <= '0;
                best_cnt <= '0;
                state <= S_SCAN;
              end
              OP_CLEAR: begin
                sweep <= '0;
                clr_reply <= 1'b1;
                state <= S_CLEAR;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_ID: begin
          face <= id[FaceBits-1:0];
          col <= hit_index;
          result.matched_color <= hit ? hit_index : '0;
          if (id < 0) begin
            result.status <= ST_BACKGROUND;
            state <= S_OUT;
          end else if (id >= 30'(Faces)) begin
            result.status <= ST_RANGE;
            state <= S_OUT;
          end else if (!hit) begin
            result.status <= ST_UNMATCHED;
            result.face_index <= id[FaceBits-1:0];
            state <= S_OUT;
          end else begin
            result.status <= ST_COUNTED;
            result.face_index <= id[FaceBits-1:0];
            state <= S_RMW_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: state <= S_OUT;
        S_SCAN: begin
          // data for color scan-1 arrives this cycle
          if (scan_live && eligible && ram_rdata > best_cnt) begin
            best_found <= 1'b1;
            best <= scan_col;
            best_cnt <= ram_rdata;
          end
          scan_live <= 1'b1;
          scan <= scan + 1'b1;
          if (scan == (ColorBits+1)'(Colors)) begin
            state <= S_WIN;
          end
        end
        // last compare has settled, load the query answer
        S_WIN: begin
          result.status <= ST_QUERY;
          result.face_index <= item.face_select;
          result.winner_found <= best_found;
          result.winner_color <= best;
          result.winner_count <= best_cnt;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pixel path never writes while the output stage is offered
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !ram_we)
    else $error("count write during output");
  // a transfer in is only taken when the output is empty
  assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("input and output overlap");
  // counted pixels went through a memory write
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) && out_ch.payload.status == ST_COUNTED |-> $past(ram_we))
    else $error("counted without write");
endmodule
`default_nettype wire

// ===== hdl/scmv_ram.sv =====
`default_nettype none
module scmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/scmv_palette.sv =====
`default_nettype none
module scmv_palette import scmv_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 we,
  input  wire logic [ColorBits-1:0] windex,
  input  wire logic                 wexcl,
  input  wire logic [23:0]          wrgb,
  input  wire logic [23:0]          match_rgb,
  output logic                      hit,
  output logic      [ColorBits-1:0] hit_index,
  input  wire logic [ColorBits-1:0] elig_index,
  output logic                      eligible
);
  logic [Colors-1:0] valid;
  logic [Colors-1:0] excl;
  logic [23:0]       rgb [Colors];

  // palette entries in flops, valid cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[windex] <= 1'b1;
    end
    if (we) begin
      excl[windex] <= wexcl;
      rgb[windex] <= wrgb;
    end
  end

  // lowest matching valid index
  always_comb begin
    hit = 1'b0;
    hit_index = '0;
    for (int i = Colors - 1; i >= 0; i--) begin
      if (valid[i] && rgb[i] == match_rgb) begin
        hit = 1'b1;
        hit_index = ColorBits'(i);
      end
    end
  end

  assign eligible = valid[elig_index] && !excl[elig_index];
endmodule
`default_nettype wire
